/* hw/rtl/tci_pkg.sv */
package tci_pkg;

  // Table capacity per unit (default)
  localparam int unsigned MaxPointsDef = 16;

  localparam int unsigned DataW   = 16;
  localparam int unsigned CntRegW = 5;

  localparam logic [DataW-1:0]   DefCarrierRst = 16'd19661;  // 1.2 V in Q2.14
  localparam logic [DataW-1:0]   DefPeakRst    = 16'd32768;  // 2.0 V in Q2.14
  localparam logic [CntRegW-1:0] PointsRst     = '0;

  localparam logic ActWrite = 1'b0;
  localparam logic ActQuery = 1'b1;

  localparam logic StatusOk    = 1'b0;
  localparam logic StatusNoSeg = 1'b1;

  typedef enum logic [1:0] {
    CfgPointsOne  = 2'd0,
    CfgPointsTwo  = 2'd1,
    CfgDefCarrier = 2'd2,
    CfgDefPeak    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic              action;
    logic              unit;
    logic [3:0]        point_index;
    logic signed [15:0] temperature;
    logic [15:0]       carrier_in;
    logic [15:0]       peak_in;
  } tci_in_t;

  typedef struct packed {
    logic [15:0] carrier_out;
    logic [15:0] peak_out;
    logic        status;
  } tci_out_t;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [15:0]        carrier;
    logic [15:0]        peak;
  } tci_entry_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quotient;
  } tci_div_rsp_t;

endpackage

/* hw/rtl/tci_div.sv */
// Restoring divider, one quotient bit per cycle. Caller guarantees
// dividend < divisor * 2^DataW, so the quotient fits DataW bits.
module tci_div import tci_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [2*DataW-1:0] dividend_i,
  input  logic [DataW-1:0]   divisor_i,
  output tci_div_rsp_t       rsp_o
);

  localparam int unsigned StepW = $clog2(DataW);

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] cnt_q;
  logic [DataW-1:0] rem_q;
  logic [DataW-1:0] lo_q;
  logic [DataW-1:0] den_q;

  logic [DataW:0]   shifted;
  logic [DataW:0]   diff;
  logic             ge;
  logic [DataW-1:0] rem_d;

  always_comb begin
    shifted = {rem_q, lo_q[DataW-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = (shifted >= {1'b0, den_q});
    rem_d   = ge ? diff[DataW-1:0] : shifted[DataW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      lo_q   <= '0;
      den_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= dividend_i[2*DataW-1:DataW];
      lo_q   <= dividend_i[DataW-1:0];
      den_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      lo_q  <= {lo_q[DataW-2:0], ge};
      cnt_q <= cnt_q + StepW'(1);
      if (cnt_q == StepW'(DataW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = lo_q;

endmodule

/* hw/rtl/temp_compensation_interpolator.sv */
// Temperature compensation interpolator for two amplifier units.
// Input channel (in_valid_i/in_ready_o/in_i) takes one item at a time: a
// write item stores one point (temperature, carrier, peak) into the unit's
// table, a query item returns the carrier and peak voltage for a temperature,
// clamped to the table ends and linearly interpolated in between.
// Output channel (out_valid_o/out_ready_i/out_o) gives exactly one item per
// input item; writes answer zeros with status ok.
// Write items and queries on an empty table (which answer the default
// voltages) go straight to the result. A query reads the first point, then
// the last point, then scans upward one point per cycle to the bracketing
// segment; each voltage then takes a multiply, a divider start and a wait on
// the 16-bit serial divide.
// One item at a time; in_ready_o is high only while the sequencer is idle.
// The table lives in one synchronous memory (2 * MaxPoints entries with a
// registered read). Reset clears counts, defaults and control state; table
// contents are undefined until written and get no clearing pass.
// The finished result sits in an output register; a new item is accepted
// while it waits. If the receiver stalls, the next result holds in the
// sequencer until the output register frees up. The user makes configuration
// writes (cfg_we_i) only while idle; the block itself does not enforce it.
module temp_compensation_interpolator import tci_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tci_in_t     in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output tci_out_t    out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [DataW-1:0] cfg_data_i
);

  localparam int unsigned Depth = 2 * MaxPoints;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned IdxW  = $clog2(MaxPoints);
  localparam int unsigned CntW  = $clog2(MaxPoints + 1);
  localparam int unsigned CmpW  = (CntW > CntRegW) ? CntW : CntRegW;

  typedef enum logic [2:0] {
    StIdle, StFirst, StLast, StScan, StMul, StDivStart, StDivWait, StDone
  } state_e;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CntRegW-1:0] cnt_one_q, cnt_two_q;
  logic [DataW-1:0]   def_carrier_q, def_peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_one_q     <= PointsRst;
      cnt_two_q     <= PointsRst;
      def_carrier_q <= DefCarrierRst;
      def_peak_q    <= DefPeakRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgPointsOne:  cnt_one_q     <= cfg_data_i[CntRegW-1:0];
        CfgPointsTwo:  cnt_two_q     <= cfg_data_i[CntRegW-1:0];
        CfgDefCarrier: def_carrier_q <= cfg_data_i;
        CfgDefPeak:    def_peak_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Table memory: unit u, point i at u * MaxPoints + i
  // ---------------------------------------------------------------------
  tci_entry_t mem_q [Depth];
  tci_entry_t rd_data_q;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             wr_en;
  tci_entry_t       wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // ---------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------
  state_e           state_q;
  logic             unit_q;
  logic [CntW-1:0]  n_q;
  logic [IdxW-1:0]  j_q;
  logic signed [DataW-1:0] tq_q;
  tci_entry_t       prev_q, cur_q;
  logic             sel_q;     // 0 carrier, 1 peak
  logic [2*DataW-1:0] prod_q;
  logic [DataW-1:0] den_q;
  logic [DataW-1:0] v0_q;
  logic             neg_q;
  tci_out_t         res_q;
  tci_out_t         out_q;
  logic             out_valid_q;

  logic in_acc;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);

  // Finished result moves into the output register
  logic out_load;
  assign out_load = (state_q == StDone) && (!out_valid_q || out_ready_i);

  // Saturated point count for the incoming item's unit
  logic [CntRegW-1:0] cnt_sel;
  logic [CmpW-1:0]    cnt_ext;
  logic [CntW-1:0]    n_in;
  logic               pidx_ok;

  always_comb begin
    cnt_sel = in_i.unit ? cnt_two_q : cnt_one_q;
    cnt_ext = CmpW'(cnt_sel);
    if (cnt_ext > CmpW'(MaxPoints)) begin
      n_in = CntW'(MaxPoints);
    end else begin
      n_in = cnt_ext[CntW-1:0];
    end
    pidx_ok = (CmpW'(in_i.point_index) < CmpW'(MaxPoints));
  end

  function automatic logic [AddrW-1:0] tbl_addr(logic u, logic [IdxW-1:0] idx);
    logic [AddrW-1:0] base;
    base = u ? AddrW'(MaxPoints) : '0;
    return base + AddrW'(idx);
  endfunction

  logic [CntW-1:0] n_m1;
  logic [IdxW-1:0] last_idx;
  assign n_m1     = n_q - CntW'(1);
  assign last_idx = n_m1[IdxW-1:0];

  // Write port: only from idle, on an accepted write item in range
  always_comb begin
    wr_en   = in_acc && (in_i.action == ActWrite) && pidx_ok;
    wr_addr = tbl_addr(in_i.unit, IdxW'(in_i.point_index));
    wr_data.temp    = in_i.temperature;
    wr_data.carrier = in_i.carrier_in;
    wr_data.peak    = in_i.peak_in;
  end

  // Read address is set in the state before the one that consumes the read data
  always_comb begin
    unique case (state_q)
      StIdle:  rd_addr = tbl_addr(in_i.unit, '0);
      StFirst: rd_addr = tbl_addr(unit_q, last_idx);
      StLast:  rd_addr = tbl_addr(unit_q, IdxW'(1));
      StScan:  rd_addr = tbl_addr(unit_q, j_q + IdxW'(1));
      default: rd_addr = tbl_addr(unit_q, '0);
    endcase
  end

  // Segment test on the freshly read point
  logic in_seg, seg_flat;
  assign in_seg   = ($signed(tq_q) >= $signed(prev_q.temp)) &&
                    ($signed(tq_q) <= $signed(rd_data_q.temp));
  assign seg_flat = (prev_q.temp == rd_data_q.temp);

  // Interpolation operands; inside a segment both differences are >= 0
  logic [DataW:0]   dt_full, den_full;
  logic [DataW-1:0] v0, v1, mag;
  logic             neg;
  always_comb begin
    dt_full  = {tq_q[DataW-1], tq_q} - {prev_q.temp[DataW-1], prev_q.temp};
    den_full = {cur_q.temp[DataW-1], cur_q.temp} - {prev_q.temp[DataW-1], prev_q.temp};
    v0       = sel_q ? prev_q.peak : prev_q.carrier;
    v1       = sel_q ? cur_q.peak  : cur_q.carrier;
    neg      = (v1 < v0);
    mag      = neg ? (v0 - v1) : (v1 - v0);
  end

  // Quotient never exceeds |v1 - v0|, so the sum stays in 0..65535
  tci_div_rsp_t     div_rsp;
  logic [DataW-1:0] lerp;
  assign lerp = neg_q ? (v0_q - div_rsp.quotient) : (v0_q + div_rsp.quotient);

  tci_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == StDivStart),
    .dividend_i (prod_q),
    .divisor_i  (den_q),
    .rsp_o      (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      unit_q      <= 1'b0;
      n_q         <= '0;
      j_q         <= '0;
      tq_q        <= '0;
      prev_q      <= '0;
      cur_q       <= '0;
      sel_q       <= 1'b0;
      prod_q      <= '0;
      den_q       <= '0;
      v0_q        <= '0;
      neg_q       <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            unit_q <= in_i.unit;
            n_q    <= n_in;
            tq_q   <= in_i.temperature;
            if (in_i.action == ActWrite) begin
              res_q   <= '0;
              state_q <= StDone;
            end else if (n_in == '0) begin
              res_q   <= '{carrier_out: def_carrier_q, peak_out: def_peak_q,
                           status: StatusOk};
              state_q <= StDone;
            end else begin
              res_q   <= '0;
              state_q <= StFirst;
            end
          end
        end

        StFirst: begin
          prev_q <= rd_data_q;
          if ($signed(tq_q) <= $signed(rd_data_q.temp)) begin
            res_q   <= '{carrier_out: rd_data_q.carrier, peak_out: rd_data_q.peak,
                         status: StatusOk};
            state_q <= StDone;
          end else begin
            state_q <= StLast;
          end
        end

        StLast: begin
          if ($signed(tq_q) >= $signed(rd_data_q.temp)) begin
            res_q   <= '{carrier_out: rd_data_q.carrier, peak_out: rd_data_q.peak,
                         status: StatusOk};
            state_q <= StDone;
          end else begin
            j_q     <= IdxW'(1);
            state_q <= StScan;
          end
        end

        // rd_data_q holds point j_q, prev_q point j_q - 1
        StScan: begin
          if (in_seg) begin
            if (seg_flat) begin
              res_q   <= '{carrier_out: prev_q.carrier, peak_out: prev_q.peak,
                           status: StatusOk};
              state_q <= StDone;
            end else begin
              cur_q   <= rd_data_q;
              sel_q   <= 1'b0;
              state_q <= StMul;
            end
          end else if (j_q == last_idx) begin
            // unsorted table: nothing brackets the temperature
            res_q.status <= StatusNoSeg;
            state_q      <= StDone;
          end else begin
            prev_q <= rd_data_q;
            j_q    <= j_q + IdxW'(1);
          end
        end

        StMul: begin
          prod_q  <= dt_full[DataW-1:0] * mag;
          den_q   <= den_full[DataW-1:0];
          v0_q    <= v0;
          neg_q   <= neg;
          state_q <= StDivStart;
        end

        StDivStart: begin
          state_q <= StDivWait;
        end

        StDivWait: begin
          if (div_rsp.done) begin
            if (!sel_q) begin
              res_q.carrier_out <= lerp;
              sel_q             <= 1'b1;
              state_q           <= StMul;
            end else begin
              res_q.peak_out <= lerp;
              state_q        <= StDone;
            end
          end
        end

        StDone: begin
          if (out_load) begin
            out_q   <= res_q;
            state_q <= StIdle;
          end
        end

        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* hw/rtl/tci_checker.sv */
module tci_checker import tci_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input tci_out_t out_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

  // One item in flight: accepting an item closes the input side
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // A new result only comes after the sequencer has been working
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without work");

  // Error results carry zero voltages
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == StatusNoSeg) |->
      (out_o.carrier_out == '0) && (out_o.peak_out == '0))
    else $error("error result with nonzero voltage");

endmodule

bind temp_compensation_interpolator tci_checker u_tci_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

/* verif/testbench.sv */
module testbench;
  import tci_pkg::*;

  localparam int Depth = MaxPointsDef;
  localparam int TotalItems = 950;
  localparam int TimeoutCycles = 600000;
  localparam logic [7:0] StallPat = 8'b1011_0010;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  tci_in_t         in_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  tci_out_t        out_o;
  logic            cfg_we_i = 1'b0;
  logic [1:0]      cfg_idx_i = '0;
  logic [DataW-1:0] cfg_data_i = '0;

  temp_compensation_interpolator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the block: both unit tables, point counts, defaults.
  logic signed [15:0] pt_temp    [2][Depth];
  logic [15:0]        pt_carrier [2][Depth];
  logic [15:0]        pt_peak    [2][Depth];
  logic [4:0]         point_cnt  [2];
  logic [15:0]        dflt_carrier;
  logic [15:0]        dflt_peak;

  tci_out_t pending_voltages [$];
  tci_out_t want_res;
  int errors = 0;
  int items_sent = 0;
  int n_write = 0, n_default = 0, n_clamp = 0, n_interp = 0, n_noseg = 0;

  // Sender pacing
  bit steady_sender = 1'b0;
  int burst_left = 0;

  // v0 + (T - t0) * (v1 - v0) / (t1 - t0), quotient truncated toward zero
  function automatic logic [15:0] lerp_volt(int tq, int t0, int t1,
                                            logic [15:0] v0, logic [15:0] v1);
    longint num, r;
    num = longint'(tq - t0) * (longint'(v1) - longint'(v0));
    r = longint'(v0) + num / longint'(t1 - t0);
    if (r < 0) r = 0;
    else if (r > 65535) r = 65535;
    return r[15:0];
  endfunction

  // Applies one item to the shadow tables and returns the voltages it answers.
  function automatic tci_out_t predict_voltages(tci_in_t it);
    tci_out_t res;
    int n, tq, t0, t1;
    logic u;
    res = '0;
    res.status = StatusOk;
    u = it.unit;
    if (it.action == ActWrite) begin
      n_write++;
      if (int'(it.point_index) < Depth) begin
        pt_temp[u][it.point_index]    = it.temperature;
        pt_carrier[u][it.point_index] = it.carrier_in;
        pt_peak[u][it.point_index]    = it.peak_in;
      end
      return res;
    end
    n = (int'(point_cnt[u]) > Depth) ? Depth : int'(point_cnt[u]);
    if (n == 0) begin
      n_default++;
      res.carrier_out = dflt_carrier;
      res.peak_out    = dflt_peak;
      return res;
    end
    tq = int'($signed(it.temperature));
    if (tq <= int'(pt_temp[u][0])) begin
      n_clamp++;
      res.carrier_out = pt_carrier[u][0];
      res.peak_out    = pt_peak[u][0];
      return res;
    end
    if (tq >= int'(pt_temp[u][n-1])) begin
      n_clamp++;
      res.carrier_out = pt_carrier[u][n-1];
      res.peak_out    = pt_peak[u][n-1];
      return res;
    end
    for (int i = 0; i + 1 < n; i++) begin
      t0 = pt_temp[u][i];
      t1 = pt_temp[u][i+1];
      if (tq >= t0 && tq <= t1) begin
        n_interp++;
        if (t1 == t0) begin
          res.carrier_out = pt_carrier[u][i];
          res.peak_out    = pt_peak[u][i];
        end else begin
          res.carrier_out = lerp_volt(tq, t0, t1, pt_carrier[u][i], pt_carrier[u][i+1]);
          res.peak_out    = lerp_volt(tq, t0, t1, pt_peak[u][i], pt_peak[u][i+1]);
        end
        return res;
      end
    end
    n_noseg++;
    res.status = StatusNoSeg;
    return res;
  endfunction

  function automatic tci_in_t temp_query(logic unit, int temp);
    tci_in_t it;
    it = '0;
    it.action      = ActQuery;
    it.unit        = unit;
    it.point_index = 4'($urandom);
    it.temperature = 16'(temp);
    it.carrier_in  = 16'($urandom);
    it.peak_in     = 16'($urandom);
    return it;
  endfunction

  function automatic tci_in_t point_write(logic unit, logic [3:0] idx, int temp,
                                          int carrier, int peak);
    tci_in_t it;
    it = '0;
    it.action      = ActWrite;
    it.unit        = unit;
    it.point_index = idx;
    it.temperature = 16'(temp);
    it.carrier_in  = 16'(carrier);
    it.peak_in     = 16'(peak);
    return it;
  endfunction

  function automatic int clamp_temp(int t);
    if (t < -32768) return -32768;
    if (t > 32767) return 32767;
    return t;
  endfunction

  function automatic int pick_volt();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65535;
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  // Counts: mostly small tables, with empty, full and over-capacity mixed in.
  function automatic int pick_count();
    case ($urandom_range(0, 15))
      0: return 0;
      1: return 16;
      2: return int'($urandom_range(17, 31));
      3, 4: return int'($urandom_range(7, 15));
      default: return int'($urandom_range(1, 6));
    endcase
  endfunction

  // Query temperatures aimed at the active table: on points, inside segments,
  // around both ends, plus the full signed range.
  function automatic int pick_query_temp(logic unit);
    int n, i, lo, hi, sw;
    n = (int'(point_cnt[unit]) > Depth) ? Depth : int'(point_cnt[unit]);
    if (n == 0) return int'($urandom_range(0, 65535)) - 32768;
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 5))
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: return int'(pt_temp[unit][i]);
      2, 3: begin
        if (i == n - 1 && i > 0) i--;
        lo = pt_temp[unit][i];
        hi = (i + 1 < n) ? int'(pt_temp[unit][i+1]) : lo;
        if (lo > hi) begin
          sw = lo;
          lo = hi;
          hi = sw;
        end
        return lo + int'($urandom_range(0, hi - lo));
      end
      4: return clamp_temp(int'(pt_temp[unit][0]) + int'($urandom_range(0, 8)) - 4);
      default: return clamp_temp(int'(pt_temp[unit][n-1]) + int'($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  // Drive one item at the falling edge; it is predicted at the edge that takes it.
  task automatic send_item(input tci_in_t item);
    int gap;
    gap = 0;
    if (!steady_sender) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 10);
      end
      burst_left--;
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    pending_voltages.push_back(predict_voltages(item));
    items_sent++;
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_voltages.size() != 0) @(posedge clk_i);
  endtask

  // Only called while the block is idle.
  task automatic cfg_write(input cfg_reg_e idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgPointsOne:  point_cnt[0] = data[4:0];
      CfgPointsTwo:  point_cnt[1] = data[4:0];
      CfgDefCarrier: dflt_carrier = data;
      CfgDefPeak:    dflt_peak = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Writes points 0..n-1 of one unit; non-decreasing temperatures unless shuffled.
  task automatic load_table(input logic unit, input int n, input bit shuffled);
    int t, cap;
    cap = 0;
    if (n > 1) cap = ($urandom_range(0, 1) != 0) ? 65535 / (n - 1) : $urandom_range(1, 64);
    t = -32768 + int'($urandom_range(0, 65535 - cap * (n > 0 ? n - 1 : 0)));
    for (int i = 0; i < n; i++) begin
      if (shuffled) t = int'($urandom_range(0, 65535)) - 32768;
      else if (i > 0 && $urandom_range(0, 7) != 0) t += int'($urandom_range(1, cap));
      send_item(point_write(unit, 4'(i), t, pick_volt(), pick_volt()));
    end
  endtask

  // Empty tables answer the default voltages, from reset and after rewrites.
  task automatic test_empty_table();
    send_item(temp_query(1'b0, -32768));
    send_item(temp_query(1'b1, 32767));
    drain_results();
    cfg_write(CfgDefCarrier, 16'hFFFF);
    cfg_write(CfgDefPeak, 16'h0000);
    send_item(temp_query(1'b0, 0));
    drain_results();
    cfg_write(CfgDefCarrier, 16'h0000);
    cfg_write(CfgDefPeak, 16'hFFFF);
    send_item(temp_query(1'b1, -1));
  endtask

  // Clamping at both ends, exact points and interpolation with extreme spans.
  task automatic test_clamp_interp();
    send_item(point_write(1'b0, 4'd0, -32768, 0, 65535));
    send_item(point_write(1'b0, 4'd1, 0, 65535, 0));
    send_item(point_write(1'b0, 4'd2, 32767, 12345, 54321));
    // unit two opens with two equal temperatures
    send_item(point_write(1'b1, 4'd0, 100, 1000, 2000));
    send_item(point_write(1'b1, 4'd1, 100, 3000, 4000));
    send_item(point_write(1'b1, 4'd2, 200, 5000, 6000));
    drain_results();
    cfg_write(CfgPointsOne, 16'd3);
    cfg_write(CfgPointsTwo, 16'd3);
    send_item(temp_query(1'b0, -32768));
    send_item(temp_query(1'b0, -1));
    send_item(temp_query(1'b0, 0));
    send_item(temp_query(1'b0, 1));
    send_item(temp_query(1'b0, 16384));
    send_item(temp_query(1'b0, 32767));
    send_item(temp_query(1'b1, 99));
    send_item(temp_query(1'b1, 100));
    send_item(temp_query(1'b1, 150));
    send_item(temp_query(1'b1, 201));
  endtask

  // Table written out of order: the segment scan takes the first match.
  task automatic test_unsorted_table();
    send_item(point_write(1'b1, 4'd0, 0, 100, 200));
    send_item(point_write(1'b1, 4'd1, 300, 40000, 30000));
    send_item(point_write(1'b1, 4'd2, -100, 9000, 8000));
    send_item(point_write(1'b1, 4'd3, 200, 65535, 0));
    drain_results();
    cfg_write(CfgPointsTwo, 16'd4);
    send_item(temp_query(1'b1, 50));
    send_item(temp_query(1'b1, 150));
    send_item(temp_query(1'b1, 250));
  endtask

  // Phases: fresh settings, fresh tables, then queries with some noise writes.
  task automatic test_random_phases(input int total);
    int cnt [2];
    int eff;
    logic [15:0] cdata;
    bit first;
    first = 1'b1;
    while (items_sent < total) begin
      drain_results();
      for (int u = 0; u < 2; u++) begin
        cnt[u] = pick_count();
        if (first) cnt[u] = (u == 0) ? 31 : 16;
        cdata = 16'(cnt[u]);
        // bits above the count field should be dropped
        if ($urandom_range(0, 3) == 0) cdata[15:5] = 11'($urandom);
        cfg_write((u == 0) ? CfgPointsOne : CfgPointsTwo, cdata);
      end
      cfg_write(CfgDefCarrier, 16'(pick_volt()));
      cfg_write(CfgDefPeak, 16'(pick_volt()));
      steady_sender = ($urandom_range(0, 3) == 0);
      for (int u = 0; u < 2; u++) begin
        eff = (cnt[u] > Depth) ? Depth : cnt[u];
        load_table(1'(u), eff, $urandom_range(0, 7) == 0);
      end
      repeat ($urandom_range(20, 60)) begin
        if ($urandom_range(0, 4) == 0) begin
          eff = $urandom_range(0, 1);
          eff = (cnt[eff] > Depth) ? Depth : cnt[eff];
          send_item(point_write(1'($urandom), 4'(($urandom_range(0, 1) != 0 && eff < Depth) ?
                    $urandom_range(eff, Depth - 1) : $urandom_range(0, Depth - 1)),
                    int'($urandom_range(0, 65535)) - 32768, pick_volt(), pick_volt()));
        end else begin
          eff = $urandom_range(0, 1);
          send_item(temp_query(1'(eff), pick_query_temp(1'(eff))));
        end
      end
      first = 1'b0;
    end
    steady_sender = 1'b0;
  endtask

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_voltages.size() == 0) begin
        $error("result with no item outstanding: carrier %0d peak %0d status %0d",
               out_o.carrier_out, out_o.peak_out, out_o.status);
        errors++;
      end else begin
        want_res = pending_voltages.pop_front();
        if (out_o.carrier_out !== want_res.carrier_out) begin
          $error("carrier_out: expected %0d, got %0d", want_res.carrier_out, out_o.carrier_out);
          errors++;
        end
        if (out_o.peak_out !== want_res.peak_out) begin
          $error("peak_out: expected %0d, got %0d", want_res.peak_out, out_o.peak_out);
          errors++;
        end
        if (out_o.status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, out_o.status);
          errors++;
        end
      end
    end
  end

  // Receiver backpressure: always ready, coin flips, fixed pattern, long holds.
  logic [9:0] ready_cyc = '0;
  int hold_left = 0;
  always @(negedge clk_i) begin
    ready_cyc <= ready_cyc + 10'd1;
    case (ready_cyc[9:8])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= 1'($urandom_range(0, 1));
      2'd2: out_ready_i <= StallPat[ready_cyc[2:0]];
      default: begin
        if (hold_left == 0) begin
          hold_left <= $urandom_range(1, 30);
          out_ready_i <= ~out_ready_i;
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  initial begin
    point_cnt[0] = PointsRst;
    point_cnt[1] = PointsRst;
    dflt_carrier = DefCarrierRst;
    dflt_peak    = DefPeakRst;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_clamp_interp();
    test_unsorted_table();
    test_random_phases(TotalItems);

    drain_results();
    repeat (64) @(posedge clk_i);
    $display("Ran %0d items: %0d point writes, %0d queries on empty tables,", items_sent,
             n_write, n_default);
    $display("%0d clamped to a table end, %0d on a segment, %0d with no segment.",
             n_clamp, n_interp, n_noseg);
    if (errors == 0) begin
      $display("PASS temp_compensation_interpolator");
    end else begin
      $display("FAIL temp_compensation_interpolator");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * 12);
    $display("FAIL temp_compensation_interpolator");
    $finish;
  end

endmodule
